>>> sv/ptt_pkg.sv
// Shared types, widths and codes for the periodic task timer bank.
// Used by every module of the block; no dependencies.
package ptt_pkg;

  localparam int NUM_SLOTS    = 16;
  localparam int SLOT_W       = $clog2(NUM_SLOTS);
  localparam int ALLOC_W      = SLOT_W + 1;
  localparam int RSLOT_W      = 4;
  localparam int CNT_W        = 24;
  localparam int PRESC_W      = 12;
  localparam int CHAN_W       = 3;
  localparam int PERIOD_W     = 31;
  localparam int ELAPSED_W    = CNT_W + PRESC_W + 1;
  localparam int DIV_CNT_W    = $clog2(ELAPSED_W);
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  // Input modes
  localparam logic [2:0] MODE_CREATE = 3'd0;
  localparam logic [2:0] MODE_START  = 3'd1;
  localparam logic [2:0] MODE_STOP   = 3'd2;
  localparam logic [2:0] MODE_TICK   = 3'd3;
  localparam logic [2:0] MODE_SCHED  = 3'd4;

  // Result kinds
  localparam logic [2:0] KIND_CREATED = 3'd0;
  localparam logic [2:0] KIND_FULL    = 3'd1;
  localparam logic [2:0] KIND_FIRED   = 3'd2;
  localparam logic [2:0] KIND_KICK    = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;
  localparam logic [2:0] KIND_BAD     = 3'd5;

  // Register index (paddr[2])
  localparam logic REG_PRESC = 1'b0;
  localparam logic REG_KICK  = 1'b1;

  typedef struct packed {
    logic                active;
    logic                repeating;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] countdown;
  } slot_t;

  typedef struct packed {
    logic                 start;
    logic [ELAPSED_W-1:0] dividend;
    logic [PERIOD_W-1:0]  divisor;
  } div_req_t;

endpackage

>>> sv/periodic_task_timer_bank_core.sv
// Top level of the periodic task timer bank: command decode, tick sequencer,
// ring of slot cells, output register and APB registers.
// Depends on ptt_pkg, ptt_cell and ptt_div.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid/in_ready, mode slot repeat_flag period  | request in
//          | counter_value                                   |
//  out     | out_valid/out_ready, kind result_slot           | request out
//          | kick_channel_out last                           |
//  cfg     | psel penable pwrite paddr pwdata prdata pready  | APB slave
//
// Create, start, stop, schedule: result in the output register.
// Tick: setup (counter difference, then scaling by the prescaler), then each
// slot in turn as the ring rotates past the head (NUM_SLOTS), plus an emit
// step per firing slot, with the bit-serial remainder unit run first for a
// firing periodic slot, then the kick.
// A full output register stalls the ring; no input is taken during a tick.
// Synchronous reset clears all slots, the allocation count and the counter.
module periodic_task_timer_bank_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    mode,
  input  logic [3:0]                    slot,
  input  logic                          repeat_flag,
  input  logic [ptt_pkg::PERIOD_W-1:0]  period,
  input  logic [ptt_pkg::CNT_W-1:0]     counter_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    kind,
  output logic [ptt_pkg::RSLOT_W-1:0]   result_slot,
  output logic [ptt_pkg::CHAN_W-1:0]    kick_channel_out,
  output logic                          last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptt_pkg::ADDR_W-1:0]    paddr,
  input  logic [ptt_pkg::DATA_W-1:0]    pwdata,
  output logic [ptt_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUB  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;
  localparam logic [2:0] ST_KICK = 3'd5;

  logic [2:0]                      state, state_next;
  logic [ptt_pkg::ALLOC_W-1:0]     alloc;
  logic [ptt_pkg::CNT_W-1:0]       prev_cnt;
  logic [ptt_pkg::CNT_W-1:0]       diff;
  logic [ptt_pkg::ELAPSED_W-1:0]   elapsed;
  logic [ptt_pkg::SLOT_W-1:0]      idx;
  logic [ptt_pkg::PRESC_W-1:0]     presc;
  logic [ptt_pkg::CHAN_W-1:0]      kick_chan;
  ptt_pkg::slot_t                  head_q;

  ptt_pkg::slot_t                  cell_q [ptt_pkg::NUM_SLOTS];
  ptt_pkg::slot_t                  head_next;
  ptt_pkg::slot_t                  wr_data;
  ptt_pkg::slot_t                  sel;
  ptt_pkg::slot_t                  h;
  logic [ptt_pkg::SLOT_W-1:0]      wr_idx;
  logic                            wr_en;
  logic                            shift_en;
  logic                            in_fire;
  logic                            emit_ok;
  logic                            emit;
  logic [2:0]                      e_kind;
  logic [ptt_pkg::RSLOT_W-1:0]     e_slot;
  logic [ptt_pkg::CHAN_W-1:0]      e_chan;
  logic                            e_last;
  logic                            advance;
  logic                            bad_slot;
  logic [ptt_pkg::PRESC_W:0]       presc_p1;
  logic [ptt_pkg::PERIOD_W-1:0]    eff_period;
  ptt_pkg::div_req_t               div_req;
  logic                            div_done;
  logic [ptt_pkg::PERIOD_W-1:0]    div_rem;
  logic                            cfg_wr;

  assign emit_ok  = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && emit_ok;
  assign in_fire  = in_valid && in_ready;
  assign sel      = cell_q[slot[ptt_pkg::SLOT_W-1:0]];
  assign bad_slot = (ptt_pkg::ALLOC_W'(slot) >= alloc);
  assign h        = cell_q[0];
  assign presc_p1 = {1'b0, presc} + 1'b1;
  assign eff_period = (h.period == '0) ? ptt_pkg::PERIOD_W'(1) : h.period;

  // ring of slot cells; the head's result re-enters at the tail
  for (genvar i = 0; i < ptt_pkg::NUM_SLOTS; i++) begin : g_cell
    ptt_pkg::slot_t nb;
    if (i == ptt_pkg::NUM_SLOTS - 1) begin : g_tail
      assign nb = head_next;
    end else begin : g_mid
      assign nb = cell_q[i+1];
    end
    ptt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (shift_en),
      .shift_in (nb),
      .wr_en    (wr_en && (wr_idx == ptt_pkg::SLOT_W'(i))),
      .wr_data  (wr_data),
      .st       (cell_q[i])
    );
  end

  ptt_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .rem  (div_rem)
  );

  // command decode and tick sequencer
  always_comb begin
    state_next       = state;
    emit             = 1'b0;
    e_kind           = ptt_pkg::KIND_CREATED;
    e_slot           = '0;
    e_chan           = '0;
    e_last           = 1'b1;
    wr_en            = 1'b0;
    wr_idx           = alloc[ptt_pkg::SLOT_W-1:0];
    wr_data          = '0;
    shift_en         = 1'b0;
    head_next        = h;
    advance          = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = elapsed - ptt_pkg::ELAPSED_W'(h.countdown);
    div_req.divisor  = eff_period;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (mode)
            ptt_pkg::MODE_CREATE, ptt_pkg::MODE_SCHED: begin
              emit = 1'b1;
              if (alloc == ptt_pkg::ALLOC_W'(ptt_pkg::NUM_SLOTS)) begin
                e_kind = ptt_pkg::KIND_FULL;
              end else begin
                wr_en             = 1'b1;
                wr_data.active    = (mode == ptt_pkg::MODE_SCHED);
                wr_data.repeating = repeat_flag;
                wr_data.period    = (mode == ptt_pkg::MODE_SCHED) ? period : '0;
                wr_data.countdown = (mode == ptt_pkg::MODE_SCHED) ? period : '0;
                e_kind            = ptt_pkg::KIND_CREATED;
                e_slot            = ptt_pkg::RSLOT_W'(alloc[ptt_pkg::SLOT_W-1:0]);
              end
            end
            ptt_pkg::MODE_START, ptt_pkg::MODE_STOP: begin
              emit   = 1'b1;
              e_slot = slot;
              if (bad_slot) begin
                e_kind = ptt_pkg::KIND_BAD;
              end else begin
                wr_en   = 1'b1;
                wr_idx  = slot[ptt_pkg::SLOT_W-1:0];
                wr_data = sel;
                e_kind  = ptt_pkg::KIND_DONE;
                if (mode == ptt_pkg::MODE_START) begin
                  wr_data.active    = 1'b1;
                  wr_data.period    = period;
                  wr_data.countdown = period;
                end else begin
                  wr_data.active = 1'b0;
                end
              end
            end
            ptt_pkg::MODE_TICK: state_next = ST_MUL;
            default: ;
          endcase
        end
      end
      ST_MUL: state_next = ST_SUB;
      ST_SUB: begin
        if (!h.active) begin
          shift_en = 1'b1;
          advance  = 1'b1;
        end else if (ptt_pkg::ELAPSED_W'(h.countdown) > elapsed) begin
          head_next.countdown = h.countdown - elapsed[ptt_pkg::PERIOD_W-1:0];
          shift_en            = 1'b1;
          advance             = 1'b1;
        end else if (h.repeating) begin
          div_req.start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_ok) begin
          emit      = 1'b1;
          e_kind    = ptt_pkg::KIND_FIRED;
          e_slot    = ptt_pkg::RSLOT_W'(idx);
          e_last    = 1'b0;
          head_next = head_q;
          shift_en  = 1'b1;
          advance   = 1'b1;
        end
      end
      ST_KICK: begin
        if (emit_ok) begin
          emit       = 1'b1;
          e_kind     = ptt_pkg::KIND_KICK;
          e_chan     = kick_chan;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (advance) begin
      state_next = (idx == ptt_pkg::SLOT_W'(ptt_pkg::NUM_SLOTS - 1)) ? ST_KICK : ST_SUB;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      alloc    <= '0;
      prev_cnt <= '0;
      idx      <= '0;
    end else begin
      state <= state_next;
      if (wr_en && state == ST_IDLE &&
          (mode == ptt_pkg::MODE_CREATE || mode == ptt_pkg::MODE_SCHED)) begin
        alloc <= alloc + 1'b1;
      end
      if (in_fire && mode == ptt_pkg::MODE_TICK) begin
        prev_cnt <= counter_value;
      end
      if (state == ST_MUL) begin
        idx <= '0;
      end else if (advance) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // tick datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      diff <= counter_value - prev_cnt;
    end
    if (state == ST_MUL) begin
      elapsed <= ptt_pkg::ELAPSED_W'(diff) * ptt_pkg::ELAPSED_W'(presc_p1);
    end
    // fired slot: one-shot goes idle and clears, periodic reloads
    if (state == ST_SUB) begin
      head_q <= {1'b0, h.repeating, h.period, ptt_pkg::PERIOD_W'(0)};
    end else if (state == ST_DIV && div_done) begin
      head_q <= {1'b1, head_q.repeating, head_q.period, eff_period - div_rem};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind             <= e_kind;
      result_slot      <= e_slot;
      kick_channel_out <= e_chan;
      last             <= e_last;
    end
  end

  // APB registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      presc     <= '0;
      kick_chan <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        ptt_pkg::REG_PRESC: presc     <= pwdata[ptt_pkg::PRESC_W-1:0];
        ptt_pkg::REG_KICK:  kick_chan <= pwdata[ptt_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ptt_pkg::REG_KICK: prdata = ptt_pkg::DATA_W'(kick_chan);
      default:           prdata = ptt_pkg::DATA_W'(presc);
    endcase
  end

endmodule

>>> sv/ptt_cell.sv
// One timer slot of the ring: holds a slot's state, loads on a command
// write and takes its neighbor's state on a ring shift. Depends on ptt_pkg.
module ptt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift_en,
  input  ptt_pkg::slot_t shift_in,
  input  logic           wr_en,
  input  ptt_pkg::slot_t wr_data,
  output ptt_pkg::slot_t st
);

  // command write wins; otherwise follow the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (wr_en) begin
      st <= wr_data;
    end else if (shift_en) begin
      st <= shift_in;
    end
  end

endmodule

>>> sv/ptt_div.sv
// Restoring remainder unit, one dividend bit per cycle.
// Gives dividend mod divisor for the periodic reload. Depends on ptt_pkg.
module ptt_div (
  input  logic                          clk,
  input  logic                          rst,
  input  ptt_pkg::div_req_t             req,
  output logic                          done,
  output logic [ptt_pkg::PERIOD_W-1:0]  rem
);

  logic                            busy;
  logic [ptt_pkg::DIV_CNT_W-1:0]   cnt;
  logic [ptt_pkg::ELAPSED_W-1:0]   dvd;
  logic [ptt_pkg::PERIOD_W-1:0]    dvs;
  logic [ptt_pkg::PERIOD_W:0]      trial;
  logic [ptt_pkg::PERIOD_W-1:0]    rem_next;

  // shift in next bit, subtract when it fits
  always_comb begin
    trial = {rem, dvd[ptt_pkg::ELAPSED_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = ptt_pkg::PERIOD_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[ptt_pkg::PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ptt_pkg::DIV_CNT_W'(ptt_pkg::ELAPSED_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= dvd << 1;
    end
  end

endmodule

>>> sv/ptt_checker.sv
// Port-level checks for the periodic task timer bank and their binding.
// Depends on ptt_pkg and periodic_task_timer_bank_core.
module ptt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] kind,
  input logic [2:0] kick_channel_out,
  input logic       last
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind))
    else $error("result changed while stalled");

  // no new request while a result is stuck
  a_noreq: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken with full output");

  // kick always ends a tick, fires never do
  a_kick_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == ptt_pkg::KIND_KICK |-> last)
    else $error("kick not last");

  a_fire_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == ptt_pkg::KIND_FIRED |-> !last && kick_channel_out == '0)
    else $error("fire result malformed");

endmodule

bind periodic_task_timer_bank_core ptt_checker u_ptt_checker (
  .clk              (clk),
  .rst              (rst),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .kind             (kind),
  .kick_channel_out (kick_channel_out),
  .last             (last)
);
